[sv/i2c_register_access_master_macros.svh]
// Assertion macros shared by the I2C register access master.
`ifndef I2C_REGISTER_ACCESS_MASTER_MACROS_SVH
`define I2C_REGISTER_ACCESS_MASTER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define I2CM_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("i2cm assertion failed (same cycle)");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define I2CM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("i2cm assertion failed (next cycle)");

`endif

[sv/i2cm_pkg.sv]
// Types and constants of the I2C register access master.
package i2cm_pkg;

  typedef enum logic [3:0] {
    PH_IDLE = 4'd0,
    PH_ST_A = 4'd1,
    PH_ST_B = 4'd2,
    PH_SEND = 4'd3,
    PH_RS_A = 4'd4,
    PH_RS_B = 4'd5,
    PH_RS_C = 4'd6,
    PH_RECV = 4'd7,
    PH_NACK = 4'd8,
    PH_SP_A = 4'd9,
    PH_SP_B = 4'd10,
    PH_SP_C = 4'd11
  } phase_t;

  typedef logic [1:0] req_t;
  localparam req_t REQ_TICK  = 2'd0;
  localparam req_t REQ_WRITE = 2'd1;
  localparam req_t REQ_READ  = 2'd2;

  typedef logic [1:0] stage_t;
  localparam stage_t STAGE_DEV_W = 2'd0;
  localparam stage_t STAGE_REG   = 2'd1;
  localparam stage_t STAGE_DATA  = 2'd2;
  localparam stage_t STAGE_DEV_R = 2'd3;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_DEV_ADDR = 2'd0;
  localparam cfg_idx_t CFG_HALF     = 2'd1;
  localparam cfg_idx_t CFG_TIMEOUT  = 2'd2;

  localparam logic [6:0] DEV_ADDR_RST = 7'd104;
  localparam logic [7:0] HALF_RST     = 8'd2;
  localparam logic [7:0] TIMEOUT_RST  = 8'd250;
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

endpackage

[sv/i2cm_if.sv]
// Request, result and configuration channel interfaces of the I2C master.
interface i2cm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] reg_addr;
  logic [7:0] write_data;
  logic       sda_in;
  modport source (output valid, output req_type, output reg_addr, output write_data,
                  output sda_in, input ready);
  modport sink (input valid, input req_type, input reg_addr, input write_data,
                input sda_in, output ready);
endinterface

interface i2cm_out_if;
  logic       valid;
  logic       ready;
  logic       scl;
  logic       sda_low;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_data;
  logic       ack_error;
  modport source (output valid, output scl, output sda_low, output busy_res,
                  output done_res, output read_data, output ack_error, input ready);
  modport sink (input valid, input scl, input sda_low, input busy_res,
                input done_res, input read_data, input ack_error, output ready);
endinterface

interface i2cm_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] reg_index;
  logic [7:0] wdata;
  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

[sv/i2c_register_access_master.sv]
// Top level of the I2C register access master: tick sequencer and result register.
//
//   channel  direction  carries
//   in_ch    sink       one tick: req_type, reg_addr, write_data, sda_in
//   out_ch   source     one result per tick: scl, sda_low, busy, done, read_data, ack_error
//   cfg_ch   sink       register writes: reg_index, wdata
//
// One request per clock while in_ch.ready is high; its result is registered and valid on the next cycle.
// The tick sequencer state advances only when a request is accepted.
// in_ch.ready drops only while a result waits and out_ch.ready is low.
// Synchronous active-low reset restores the idle bus and default registers.
`include "i2c_register_access_master_macros.svh"

module i2c_register_access_master (
  input  logic clk,
  input  logic rst_n,
  i2cm_in_if.sink    in_ch,
  i2cm_out_if.source out_ch,
  i2cm_cfg_if.sink   cfg_ch
);

  logic [6:0] dev_addr_r;
  logic [7:0] half_r, timeout_r;

  i2cm_pkg::phase_t phase_r, phase_nxt, ph_eff;
  logic [3:0] bit_count_r, bit_count_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [7:0] tick_r, tick_nxt, tick_eff, tick_inc;
  logic [7:0] wait_r, wait_nxt;
  logic       is_read_r, is_read_nxt;
  logic [7:0] held_addr_r, held_addr_nxt;
  logic [7:0] held_data_r, held_data_nxt;
  logic [7:0] recv_r, recv_nxt;
  logic       err_r, err_nxt;
  i2cm_pkg::stage_t stage_r, stage_nxt;
  logic       hh_r, hh_nxt;

  logic       out_valid_r;
  logic       scl_r, sdl_r, busy_r, done_r, ack_err_r;
  logic [7:0] rdata_r;
  logic       scl_c, sdl_c, busy_c, done_c;

  logic       in_acc, start_req, seg_end;
  logic [7:0] half_eff;

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign half_eff  = (half_r == 8'd0) ? 8'd1 : half_r;
  assign start_req = (phase_r == i2cm_pkg::PH_IDLE) &&
                     ((in_ch.req_type == i2cm_pkg::REQ_WRITE) ||
                      (in_ch.req_type == i2cm_pkg::REQ_READ));
  assign ph_eff    = start_req ? i2cm_pkg::PH_ST_A : phase_r;
  assign tick_eff  = start_req ? 8'd0 : tick_r;
  assign tick_inc  = tick_eff + 8'd1;
  assign seg_end   = ({1'b0, tick_eff} + 9'd1) >= {1'b0, half_eff};

  always_comb begin
    phase_nxt     = ph_eff;
    bit_count_nxt = bit_count_r;
    shift_nxt     = shift_r;
    tick_nxt      = tick_eff;
    wait_nxt      = wait_r;
    is_read_nxt   = start_req ? (in_ch.req_type == i2cm_pkg::REQ_READ) : is_read_r;
    held_addr_nxt = start_req ? in_ch.reg_addr : held_addr_r;
    held_data_nxt = start_req ? in_ch.write_data : held_data_r;
    recv_nxt      = recv_r;
    err_nxt       = start_req ? 1'b0 : err_r;
    stage_nxt     = stage_r;
    hh_nxt        = hh_r;
    scl_c  = 1'b1;
    sdl_c  = 1'b0;
    busy_c = 1'b1;
    done_c = 1'b0;
    unique case (ph_eff)
      i2cm_pkg::PH_IDLE: begin
        busy_c = 1'b0;
      end
      i2cm_pkg::PH_ST_A: begin
        if (seg_end) begin
          phase_nxt = i2cm_pkg::PH_ST_B;
          tick_nxt  = 8'd0;
        end else tick_nxt = tick_inc;
      end
      i2cm_pkg::PH_ST_B: begin
        sdl_c = 1'b1;
        if (seg_end) begin
          stage_nxt     = i2cm_pkg::STAGE_DEV_W;
          shift_nxt     = {dev_addr_r, 1'b0};
          phase_nxt     = i2cm_pkg::PH_SEND;
          bit_count_nxt = 4'd0;
          hh_nxt        = 1'b0;
          tick_nxt      = 8'd0;
        end else tick_nxt = tick_inc;
      end
      i2cm_pkg::PH_SEND: begin
        scl_c = hh_r;
        if (bit_count_r < i2cm_pkg::BITS_PER_BYTE) begin
          sdl_c = !shift_r[7];
          if (!seg_end) tick_nxt = tick_inc;
          else begin
            tick_nxt = 8'd0;
            if (!hh_r) hh_nxt = 1'b1;
            else begin
              hh_nxt        = 1'b0;
              shift_nxt     = {shift_r[6:0], 1'b0};
              bit_count_nxt = bit_count_r + 4'd1;
            end
          end
        end else if (!hh_r) begin
          if (seg_end) begin
            tick_nxt = 8'd0;
            hh_nxt   = 1'b1;
            wait_nxt = 8'd0;
          end else tick_nxt = tick_inc;
        end else if (in_ch.sda_in) begin
          if (wait_r >= timeout_r) begin
            err_nxt   = 1'b1;
            phase_nxt = i2cm_pkg::PH_SP_A;
            tick_nxt  = 8'd0;
          end else begin
            wait_nxt = wait_r + 8'd1;
            if (tick_eff != 8'hFF) tick_nxt = tick_inc;
          end
        end else if (!seg_end) begin
          tick_nxt = tick_inc;
        end else begin
          tick_nxt = 8'd0;
          unique case (stage_r)
            i2cm_pkg::STAGE_DEV_W: begin
              stage_nxt     = i2cm_pkg::STAGE_REG;
              shift_nxt     = held_addr_r;
              bit_count_nxt = 4'd0;
              hh_nxt        = 1'b0;
            end
            i2cm_pkg::STAGE_REG: begin
              if (is_read_r) phase_nxt = i2cm_pkg::PH_RS_A;
              else begin
                stage_nxt     = i2cm_pkg::STAGE_DATA;
                shift_nxt     = held_data_r;
                bit_count_nxt = 4'd0;
                hh_nxt        = 1'b0;
              end
            end
            i2cm_pkg::STAGE_DATA: begin
              phase_nxt = i2cm_pkg::PH_SP_A;
            end
            default: begin
              phase_nxt     = i2cm_pkg::PH_RECV;
              bit_count_nxt = 4'd0;
              hh_nxt        = 1'b0;
              shift_nxt     = 8'd0;
            end
          endcase
        end
      end
      i2cm_pkg::PH_RS_A: begin
        scl_c = 1'b0;
        if (seg_end) begin
          phase_nxt = i2cm_pkg::PH_RS_B;
          tick_nxt  = 8'd0;
        end else tick_nxt = tick_inc;
      end
      i2cm_pkg::PH_RS_B: begin
        if (seg_end) begin
          phase_nxt = i2cm_pkg::PH_RS_C;
          tick_nxt  = 8'd0;
        end else tick_nxt = tick_inc;
      end
      i2cm_pkg::PH_RS_C: begin
        sdl_c = 1'b1;
        if (seg_end) begin
          stage_nxt     = i2cm_pkg::STAGE_DEV_R;
          shift_nxt     = {dev_addr_r, 1'b1};
          phase_nxt     = i2cm_pkg::PH_SEND;
          bit_count_nxt = 4'd0;
          hh_nxt        = 1'b0;
          tick_nxt      = 8'd0;
        end else tick_nxt = tick_inc;
      end
      i2cm_pkg::PH_RECV: begin
        scl_c = hh_r;
        if (!seg_end) tick_nxt = tick_inc;
        else begin
          tick_nxt = 8'd0;
          if (!hh_r) hh_nxt = 1'b1;
          else begin
            hh_nxt        = 1'b0;
            shift_nxt     = {shift_r[6:0], in_ch.sda_in};
            bit_count_nxt = bit_count_r + 4'd1;
            if ((bit_count_r + 4'd1) >= i2cm_pkg::BITS_PER_BYTE)
              phase_nxt = i2cm_pkg::PH_NACK;
          end
        end
      end
      i2cm_pkg::PH_NACK: begin
        scl_c = hh_r;
        if (!seg_end) tick_nxt = tick_inc;
        else begin
          tick_nxt = 8'd0;
          if (!hh_r) hh_nxt = 1'b1;
          else begin
            hh_nxt    = 1'b0;
            phase_nxt = i2cm_pkg::PH_SP_A;
          end
        end
      end
      i2cm_pkg::PH_SP_A: begin
        scl_c = 1'b0;
        sdl_c = 1'b1;
        if (seg_end) begin
          phase_nxt = i2cm_pkg::PH_SP_B;
          tick_nxt  = 8'd0;
        end else tick_nxt = tick_inc;
      end
      i2cm_pkg::PH_SP_B: begin
        sdl_c = 1'b1;
        if (seg_end) begin
          phase_nxt = i2cm_pkg::PH_SP_C;
          tick_nxt  = 8'd0;
        end else tick_nxt = tick_inc;
      end
      default: begin
        if (seg_end) begin
          done_c = 1'b1;
          if (is_read_r && !err_r) recv_nxt = shift_r;
          phase_nxt     = i2cm_pkg::PH_IDLE;
          tick_nxt      = 8'd0;
          bit_count_nxt = 4'd0;
          hh_nxt        = 1'b0;
        end else tick_nxt = tick_inc;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= i2cm_pkg::DEV_ADDR_RST;
      half_r     <= i2cm_pkg::HALF_RST;
      timeout_r  <= i2cm_pkg::TIMEOUT_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.reg_index)
        i2cm_pkg::CFG_DEV_ADDR: dev_addr_r <= cfg_ch.wdata[6:0];
        i2cm_pkg::CFG_HALF:     half_r     <= cfg_ch.wdata;
        i2cm_pkg::CFG_TIMEOUT:  timeout_r  <= cfg_ch.wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= i2cm_pkg::PH_IDLE;
      bit_count_r <= 4'd0;
      shift_r     <= 8'd0;
      tick_r      <= 8'd0;
      wait_r      <= 8'd0;
      is_read_r   <= 1'b0;
      held_addr_r <= 8'd0;
      held_data_r <= 8'd0;
      recv_r      <= 8'd0;
      err_r       <= 1'b0;
      stage_r     <= i2cm_pkg::STAGE_DEV_W;
      hh_r        <= 1'b0;
    end else if (in_acc) begin
      phase_r     <= phase_nxt;
      bit_count_r <= bit_count_nxt;
      shift_r     <= shift_nxt;
      tick_r      <= tick_nxt;
      wait_r      <= wait_nxt;
      is_read_r   <= is_read_nxt;
      held_addr_r <= held_addr_nxt;
      held_data_r <= held_data_nxt;
      recv_r      <= recv_nxt;
      err_r       <= err_nxt;
      stage_r     <= stage_nxt;
      hh_r        <= hh_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      scl_r     <= scl_c;
      sdl_r     <= sdl_c;
      busy_r    <= busy_c;
      done_r    <= done_c;
      rdata_r   <= recv_nxt;
      ack_err_r <= err_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.scl       = scl_r;
  assign out_ch.sda_low   = sdl_r;
  assign out_ch.busy_res  = busy_r;
  assign out_ch.done_res  = done_r;
  assign out_ch.read_data = rdata_r;
  assign out_ch.ack_error = ack_err_r;

  `I2CM_ASSERT_SAME(a_idle_clean, phase_r == i2cm_pkg::PH_IDLE, bit_count_r == 4'd0 && !hh_r)
  `I2CM_ASSERT_SAME(a_bits_bounded, 1'b1, bit_count_r <= i2cm_pkg::BITS_PER_BYTE)
  `I2CM_ASSERT_NEXT(a_req_starts, in_acc && start_req, phase_r == i2cm_pkg::PH_ST_A || phase_r == i2cm_pkg::PH_ST_B)
  `I2CM_ASSERT_SAME(a_done_busy, out_valid_r && done_r, busy_r)

endmodule

[tb/sv/tb_i2c_register_access_master.sv]
// Self-checking testbench for the I2C register access master against a tick-level model.
`timescale 1ns / 1ps

module tb_i2c_register_access_master;

  localparam int ITEM_TARGET    = 1050;
  localparam int STEADY_FROM    = 840;
  localparam int XFER_MAX_TICKS = 170;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int REPORT_MAX     = 10;
  localparam i2cm_pkg::req_t REQ_UNUSED = 2'd3;

  typedef enum logic [1:0] {ACK_PROMPT, ACK_LATE, ACK_ABSENT} ack_style_t;

  typedef struct {
    logic       scl;
    logic       sda_low;
    logic       busy;
    logic       done;
    logic [7:0] rdata;
    logic       err;
  } bus_levels_t;

  logic clk = 1'b0;
  logic rst_n;

  i2cm_in_if  in_ch();
  i2cm_out_if out_ch();
  i2cm_cfg_if cfg_ch();

  i2c_register_access_master i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // bus model state
  i2cm_pkg::phase_t bus_ph;
  i2cm_pkg::stage_t stage;
  logic [3:0] bit_cnt;
  logic [7:0] shreg, tcnt, wcnt;
  logic       rd_mode, err_flag, hi_half;
  logic [7:0] hold_reg, hold_data, rx_byte;
  logic [6:0] dev_addr;
  logic [7:0] half_ticks, ack_limit;

  bus_levels_t pending_levels[$];
  ack_style_t  target_ack = ACK_PROMPT;
  bit          steady = 1'b0;
  int          ticks_sent = 0;
  int          bad_count = 0;
  int          sink_hold = 0;
  longint      cycle_cnt = 0;

  function automatic void load_byte(i2cm_pkg::stage_t stg, logic [7:0] b);
    stage   = stg;
    shreg   = b;
    bus_ph  = i2cm_pkg::PH_SEND;
    bit_cnt = '0;
    hi_half = 1'b0;
    tcnt    = '0;
  endfunction

  function automatic void enter(i2cm_pkg::phase_t p);
    bus_ph = p;
    tcnt   = '0;
  endfunction

  function automatic void ack_taken();
    case (stage)
      i2cm_pkg::STAGE_DEV_W: load_byte(i2cm_pkg::STAGE_REG, hold_reg);
      i2cm_pkg::STAGE_REG: begin
        if (rd_mode) enter(i2cm_pkg::PH_RS_A);
        else load_byte(i2cm_pkg::STAGE_DATA, hold_data);
      end
      i2cm_pkg::STAGE_DATA: enter(i2cm_pkg::PH_SP_A);
      default: begin
        bus_ph  = i2cm_pkg::PH_RECV;
        bit_cnt = '0;
        hi_half = 1'b0;
        shreg   = '0;
        tcnt    = '0;
      end
    endcase
  endfunction

  function automatic bus_levels_t advance_bus(i2cm_pkg::req_t req, logic [7:0] ra,
                                              logic [7:0] wd, logic sda);
    bus_levels_t r;
    logic [8:0]  half;
    logic        seg_end;
    r.scl     = 1'b1;
    r.sda_low = 1'b0;
    r.busy    = 1'b1;
    r.done    = 1'b0;
    half = (half_ticks == 8'd0) ? 9'd1 : {1'b0, half_ticks};
    if (bus_ph == i2cm_pkg::PH_IDLE &&
        (req == i2cm_pkg::REQ_WRITE || req == i2cm_pkg::REQ_READ)) begin
      rd_mode   = (req == i2cm_pkg::REQ_READ);
      hold_reg  = ra;
      hold_data = wd;
      err_flag  = 1'b0;
      enter(i2cm_pkg::PH_ST_A);
    end
    seg_end = ({1'b0, tcnt} + 9'd1) >= half;
    case (bus_ph)
      i2cm_pkg::PH_IDLE: r.busy = 1'b0;
      i2cm_pkg::PH_ST_A: begin
        if (seg_end) enter(i2cm_pkg::PH_ST_B);
        else tcnt++;
      end
      i2cm_pkg::PH_ST_B: begin
        r.sda_low = 1'b1;
        if (seg_end) load_byte(i2cm_pkg::STAGE_DEV_W, {dev_addr, 1'b0});
        else tcnt++;
      end
      i2cm_pkg::PH_SEND: begin
        r.scl = hi_half;
        if (bit_cnt < i2cm_pkg::BITS_PER_BYTE) begin
          r.sda_low = ~shreg[7];
          if (!seg_end) begin
            tcnt++;
          end else begin
            tcnt = '0;
            if (!hi_half) begin
              hi_half = 1'b1;
            end else begin
              hi_half = 1'b0;
              shreg   = shreg << 1;
              bit_cnt++;
            end
          end
        end else if (!hi_half) begin
          if (seg_end) begin
            tcnt    = '0;
            hi_half = 1'b1;
            wcnt    = '0;
          end else begin
            tcnt++;
          end
        end else if (sda) begin
          if (wcnt >= ack_limit) begin
            err_flag = 1'b1;
            enter(i2cm_pkg::PH_SP_A);
          end else begin
            wcnt++;
            if (tcnt < 8'd255) tcnt++;
          end
        end else begin
          if (seg_end) ack_taken();
          else tcnt++;
        end
      end
      i2cm_pkg::PH_RS_A: begin
        r.scl = 1'b0;
        if (seg_end) enter(i2cm_pkg::PH_RS_B);
        else tcnt++;
      end
      i2cm_pkg::PH_RS_B: begin
        if (seg_end) enter(i2cm_pkg::PH_RS_C);
        else tcnt++;
      end
      i2cm_pkg::PH_RS_C: begin
        r.sda_low = 1'b1;
        if (seg_end) load_byte(i2cm_pkg::STAGE_DEV_R, {dev_addr, 1'b1});
        else tcnt++;
      end
      i2cm_pkg::PH_RECV: begin
        r.scl = hi_half;
        if (!seg_end) begin
          tcnt++;
        end else begin
          tcnt = '0;
          if (!hi_half) begin
            hi_half = 1'b1;
          end else begin
            hi_half = 1'b0;
            shreg   = {shreg[6:0], sda};
            bit_cnt++;
            if (bit_cnt >= i2cm_pkg::BITS_PER_BYTE) begin
              bus_ph  = i2cm_pkg::PH_NACK;
              hi_half = 1'b0;
            end
          end
        end
      end
      i2cm_pkg::PH_NACK: begin
        r.scl = hi_half;
        if (!seg_end) begin
          tcnt++;
        end else begin
          tcnt = '0;
          if (!hi_half) begin
            hi_half = 1'b1;
          end else begin
            hi_half = 1'b0;
            enter(i2cm_pkg::PH_SP_A);
          end
        end
      end
      i2cm_pkg::PH_SP_A: begin
        r.scl     = 1'b0;
        r.sda_low = 1'b1;
        if (seg_end) enter(i2cm_pkg::PH_SP_B);
        else tcnt++;
      end
      i2cm_pkg::PH_SP_B: begin
        r.sda_low = 1'b1;
        if (seg_end) enter(i2cm_pkg::PH_SP_C);
        else tcnt++;
      end
      default: begin
        if (seg_end) begin
          r.done = 1'b1;
          if (rd_mode && !err_flag) rx_byte = shreg;
          enter(i2cm_pkg::PH_IDLE);
          bit_cnt = '0;
          hi_half = 1'b0;
        end else begin
          tcnt++;
        end
      end
    endcase
    r.rdata = rx_byte;
    r.err   = err_flag;
    return r;
  endfunction

  function automatic void clear_bus_model();
    bus_ph    = i2cm_pkg::PH_IDLE;
    stage     = i2cm_pkg::STAGE_DEV_W;
    bit_cnt   = '0;
    shreg     = '0;
    tcnt      = '0;
    wcnt      = '0;
    rd_mode   = 1'b0;
    err_flag  = 1'b0;
    hi_half   = 1'b0;
    hold_reg  = '0;
    hold_data = '0;
    rx_byte   = '0;
    dev_addr   = i2cm_pkg::DEV_ADDR_RST;
    half_ticks = i2cm_pkg::HALF_RST;
    ack_limit  = i2cm_pkg::TIMEOUT_RST;
  endfunction

  function automatic logic target_sda();
    if (bus_ph == i2cm_pkg::PH_SEND && bit_cnt == i2cm_pkg::BITS_PER_BYTE && hi_half) begin
      case (target_ack)
        ACK_PROMPT: return 1'b0;
        ACK_ABSENT: return 1'b1;
        default:    return ($urandom_range(0, 2) != 0);
      endcase
    end
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      bad_count++;
      if (bad_count <= REPORT_MAX)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    bus_levels_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_levels.size() == 0) begin
        bad_count++;
        if (bad_count <= REPORT_MAX)
          $display("%0t: result with no request outstanding", $time);
      end else begin
        want = pending_levels.pop_front();
        compare_field("scl", 8'(want.scl), 8'(out_ch.scl));
        compare_field("sda_low", 8'(want.sda_low), 8'(out_ch.sda_low));
        compare_field("busy_res", 8'(want.busy), 8'(out_ch.busy_res));
        compare_field("done_res", 8'(want.done), 8'(out_ch.done_res));
        compare_field("read_data", want.rdata, out_ch.read_data);
        compare_field("ack_error", 8'(want.err), 8'(out_ch.ack_error));
      end
    end
  end

  always @(negedge clk) begin
    if (steady) begin
      sink_hold = 0;
      out_ch.ready <= 1'b1;
    end else if (sink_hold > 0) begin
      sink_hold--;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      sink_hold = $urandom_range(1, 10) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAIL i2c_register_access_master");
      $finish;
    end
  end

  task automatic drive_tick(i2cm_pkg::req_t req, logic [7:0] ra, logic [7:0] wd, logic sda);
    if (!steady && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.req_type   <= req;
    in_ch.reg_addr   <= ra;
    in_ch.write_data <= wd;
    in_ch.sda_in     <= sda;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pending_levels.push_back(advance_bus(req, ra, wd, sda));
    ticks_sent++;
    @(negedge clk);
  endtask

  task automatic idle_ticks(int n);
    repeat (n)
      drive_tick($urandom_range(0, 1) ? REQ_UNUSED : i2cm_pkg::REQ_TICK,
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)));
  endtask

  // stray requests while busy must be ignored
  task automatic run_xfer(i2cm_pkg::req_t req, logic [7:0] ra, logic [7:0] wd);
    drive_tick(req, ra, wd, 1'($urandom_range(0, 1)));
    while (bus_ph != i2cm_pkg::PH_IDLE)
      drive_tick(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), target_sda());
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_levels.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic cfg_write(i2cm_pkg::cfg_idx_t idx, logic [7:0] val);
    settle();
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wdata     <= val;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    case (idx)
      i2cm_pkg::CFG_DEV_ADDR: dev_addr   = val[6:0];
      i2cm_pkg::CFG_HALF:     half_ticks = val;
      i2cm_pkg::CFG_TIMEOUT:  ack_limit  = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic test_default_write();
    target_ack = ACK_PROMPT;
    idle_ticks(2);
    run_xfer(i2cm_pkg::REQ_WRITE, 8'h00, 8'hFF);
  endtask

  task automatic test_register_extremes();
    target_ack = ACK_PROMPT;
    cfg_write(i2cm_pkg::CFG_HALF, 8'd1);
    cfg_write(i2cm_pkg::CFG_DEV_ADDR, 8'd127);
    run_xfer(i2cm_pkg::REQ_WRITE, 8'hFF, 8'h00);
    cfg_write(i2cm_pkg::CFG_DEV_ADDR, 8'd0);
    idle_ticks(1);
    run_xfer(i2cm_pkg::REQ_READ, 8'hFF, 8'h5A);
  endtask

  task automatic test_missing_ack();
    target_ack = ACK_ABSENT;
    cfg_write(i2cm_pkg::CFG_TIMEOUT, 8'd0);
    run_xfer(i2cm_pkg::REQ_WRITE, 8'h12, 8'h34);
    cfg_write(i2cm_pkg::CFG_TIMEOUT, 8'd1);
    run_xfer(i2cm_pkg::REQ_READ, 8'h56, 8'h00);
    target_ack = ACK_LATE;
    cfg_write(i2cm_pkg::CFG_TIMEOUT, 8'd3);
    run_xfer(i2cm_pkg::REQ_READ, 8'h9A, 8'h00);
    target_ack = ACK_ABSENT;
    cfg_write(i2cm_pkg::CFG_TIMEOUT, 8'd9);
    run_xfer(i2cm_pkg::REQ_WRITE, 8'h01, 8'h80);
    target_ack = ACK_PROMPT;
    run_xfer(i2cm_pkg::REQ_READ, 8'h77, 8'h00);
  endtask

  task automatic test_half_period_extremes();
    target_ack = ACK_PROMPT;
    cfg_write(i2cm_pkg::CFG_HALF, 8'd0);
    run_xfer(i2cm_pkg::REQ_READ, 8'hC0, 8'h00);
    cfg_write(i2cm_pkg::CFG_HALF, 8'd1);
  endtask

  task automatic test_random_traffic();
    int pick;
    while (ticks_sent + XFER_MAX_TICKS < ITEM_TARGET) begin
      steady = ticks_sent >= STEADY_FROM;
      if (!steady && $urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 2))
          0:       cfg_write(i2cm_pkg::CFG_DEV_ADDR, 8'($urandom_range(0, 127)));
          1:       cfg_write(i2cm_pkg::CFG_HALF, 8'($urandom_range(0, 2)));
          default: cfg_write(i2cm_pkg::CFG_TIMEOUT,
                             8'(($urandom_range(0, 3) == 0) ? 250 : $urandom_range(0, 6)));
        endcase
      end
      pick = $urandom_range(0, 19);
      if (steady) target_ack = ACK_PROMPT;
      else target_ack = (pick < 14) ? ACK_PROMPT : (pick < 17) ? ACK_LATE : ACK_ABSENT;
      idle_ticks($urandom_range(0, 3));
      run_xfer($urandom_range(0, 1) ? i2cm_pkg::REQ_READ : i2cm_pkg::REQ_WRITE,
               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end
    steady = 1'b1;
    if (ticks_sent < ITEM_TARGET) idle_ticks(ITEM_TARGET - ticks_sent);
  endtask

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.req_type   = i2cm_pkg::REQ_TICK;
    in_ch.reg_addr   = '0;
    in_ch.write_data = '0;
    in_ch.sda_in     = 1'b1;
    cfg_ch.valid     = 1'b0;
    cfg_ch.reg_index = i2cm_pkg::CFG_DEV_ADDR;
    cfg_ch.wdata     = '0;
    clear_bus_model();
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_default_write();
    test_register_extremes();
    test_missing_ack();
    test_half_period_extremes();
    test_random_traffic();

    settle();
    repeat (4) @(negedge clk);
    if (bad_count == 0 && pending_levels.size() == 0) begin
      $display("PASS i2c_register_access_master");
    end else begin
      $display("FAIL i2c_register_access_master");
    end
    $finish;
  end

endmodule
